/* rtl/sfrp_pkg.sv */
// Shared types, constants and helpers of the sync-word framed request parser.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
`default_nettype none

package sfrp_pkg;

   // Sizes
   localparam int MAX_PAYLOAD   = 32;
   localparam int PAY_AW        = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int PAY_CNT_W     = $clog2(MAX_PAYLOAD + 1);
   localparam int ERR_FRAME_LEN = 7;
   localparam int IDX_W         = (PAY_CNT_W > 3) ? PAY_CNT_W : 3;
   localparam int LEN_W         = 6;
   localparam int SYNC_LEN      = 8;
   localparam int SYNC_CNT_W    = 3;
   localparam int HDR_LEN       = 4;
   localparam int HDR_CNT_W     = 3;
   // queue depth, kept a power of two so the pointers wrap on their own
   localparam int CMDQ_DEPTH    = 2;
   localparam int CMDQ_PTR_W    = 1;
   localparam int CMDQ_CNT_W    = 2;

   // Unlock sequence (first byte at index 0) and error response sync byte
   localparam logic [SYNC_LEN-1:0][7:0] SYNC_SEQ = {
      8'hAC, 8'h58, 8'h99, 8'h7C, 8'h20, 8'hED, 8'h3E, 8'h91
   };
   localparam logic [7:0] RESP_SYNC = 8'hAC;

   // Input actions
   localparam logic [1:0] ACT_BYTE   = 2'd0;
   localparam logic [1:0] ACT_TICK   = 2'd1;
   localparam logic [1:0] ACT_CANCEL = 2'd2;

   // Response kinds
   localparam logic [1:0] KIND_SYNC = 2'd0;
   localparam logic [1:0] KIND_REQ  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Commands from front to back
   localparam logic [1:0] CMD_SYNC   = 2'd0;
   localparam logic [1:0] CMD_ACCEPT = 2'd1;
   localparam logic [1:0] CMD_ERROR  = 2'd2;

   // Register indexes and reset values
   localparam logic [1:0]  CSR_TIMEOUT    = 2'd0;
   localparam logic [1:0]  CSR_STATUS_IO  = 2'd1;
   localparam logic [1:0]  CSR_STATUS_LEN = 2'd2;
   localparam logic [1:0]  CSR_STATUS_SUM = 2'd3;
   localparam logic [15:0] TIMEOUT_RST    = 16'd100;
   localparam logic [7:0]  STATUS_IO_RST  = 8'd1;
   localparam logic [7:0]  STATUS_LEN_RST = 8'd2;
   localparam logic [7:0]  STATUS_SUM_RST = 8'd3;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0]  status_io_error;
      logic [7:0]  status_length_error;
      logic [7:0]  status_sum_error;
   } csr_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [7:0]       status;
      logic [7:0]       module_id;
      logic [7:0]       command;
      logic [7:0]       parameter_res;
      logic [LEN_W-1:0] length;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [PAY_AW-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   function automatic cmd_type make_cmd(input logic [1:0] op, input logic [7:0] status,
                                        input logic [7:0] m, input logic [7:0] c,
                                        input logic [7:0] p,
                                        input logic [LEN_W-1:0] len);
      cmd_type r;
      r.op            = op;
      r.status        = status;
      r.module_id     = m;
      r.command       = c;
      r.parameter_res = p;
      r.length        = len;
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/sfrp_front.sv */
// Front end: sequence hunt, header/payload/checksum collection and timeout.
// Issues one command per finished event; writes payload into the back end's store.
// Depends on sfrp_pkg.
`default_nettype none

module sfrp_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire logic [1:0]             action,
   input  wire logic [7:0]             byte_in,
   input  wire sfrp_pkg::csr_type      csr,
   output logic                        cmd_push,
   output sfrp_pkg::cmd_type           cmd,
   input  wire logic                   cmd_full,
   output sfrp_pkg::store_wr_type      store_wr,
   input  wire logic                   burst_done,
   output logic                        store_busy
);

   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_HEADER  = 2'd1;
   localparam logic [1:0] MODE_PAYLOAD = 2'd2;
   localparam logic [1:0] MODE_CHECK   = 2'd3;

   logic [1:0]                        mode_ff, mode_in;
   logic [sfrp_pkg::SYNC_CNT_W-1:0]   sync_ff, sync_in;
   logic [sfrp_pkg::HDR_CNT_W-1:0]    hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]                        hdr_ff [sfrp_pkg::HDR_LEN];
   logic [7:0]                        hdr_in [sfrp_pkg::HDR_LEN];
   logic [sfrp_pkg::PAY_CNT_W-1:0]    pay_cnt_ff, pay_cnt_in;
   logic [7:0]                        sum_ff, sum_in;
   logic [15:0]                       ticks_ff, ticks_in;
   logic                              busy_ff, busy_in;

   logic                              accept;
   logic [sfrp_pkg::SYNC_CNT_W:0]     sync_nx;
   logic [15:0]                       ticks_inc;
   logic [7:0]                        m_part, c_part, p_part;

   // stall on a full queue, or on payload while the store still feeds a burst
   assign full       = cmd_full || ((mode_ff == MODE_PAYLOAD) && busy_ff);
   assign accept     = push && !full;
   assign store_busy = busy_ff;

   // header bytes seen so far, missing ones read as zero
   assign m_part = (hdr_cnt_ff > 3'd0) ? hdr_ff[0] : 8'd0;
   assign c_part = (hdr_cnt_ff > 3'd1) ? hdr_ff[1] : 8'd0;
   assign p_part = (hdr_cnt_ff > 3'd2) ? hdr_ff[2] : 8'd0;

   assign sync_nx   = (byte_in == sfrp_pkg::SYNC_SEQ[sync_ff])
                    ? ({1'b0, sync_ff} + 4'd1)
                    : ((byte_in == sfrp_pkg::SYNC_SEQ[0]) ? 4'd1 : 4'd0);
   assign ticks_inc = (ticks_ff == 16'hFFFF) ? ticks_ff : (ticks_ff + 16'd1);

   // parser next state
   always_comb begin
      mode_in    = mode_ff;
      sync_in    = sync_ff;
      hdr_cnt_in = hdr_cnt_ff;
      hdr_in     = hdr_ff;
      pay_cnt_in = pay_cnt_ff;
      sum_in     = sum_ff;
      ticks_in   = ticks_ff;
      busy_in    = busy_ff;
      cmd_push   = 1'b0;
      cmd        = '0;
      store_wr   = '0;

      if (burst_done) begin
         busy_in = 1'b0;
      end

      if (accept) begin
         case (action)
            sfrp_pkg::ACT_CANCEL: begin
               sync_in = '0;
            end
            sfrp_pkg::ACT_TICK: begin
               if (mode_ff != MODE_IDLE) begin
                  ticks_in = ticks_inc;
                  if (ticks_inc >= csr.timeout_ticks) begin
                     cmd_push   = 1'b1;
                     cmd        = sfrp_pkg::make_cmd(sfrp_pkg::CMD_ERROR,
                                     csr.status_io_error, m_part, c_part, p_part, '0);
                     mode_in    = MODE_IDLE;
                     hdr_cnt_in = '0;
                     pay_cnt_in = '0;
                     sum_in     = '0;
                     ticks_in   = '0;
                  end
               end
            end
            sfrp_pkg::ACT_BYTE: begin
               if (mode_ff == MODE_IDLE) begin
                  // sequence hunt
                  if (sync_nx == 4'(sfrp_pkg::SYNC_LEN)) begin
                     sync_in    = '0;
                     mode_in    = MODE_HEADER;
                     hdr_cnt_in = '0;
                     pay_cnt_in = '0;
                     sum_in     = '0;
                     ticks_in   = '0;
                     cmd_push   = 1'b1;
                     cmd        = sfrp_pkg::make_cmd(sfrp_pkg::CMD_SYNC,
                                     8'd0, 8'd0, 8'd0, 8'd0, '0);
                  end else begin
                     sync_in = sync_nx[sfrp_pkg::SYNC_CNT_W-1:0];
                  end
               end else begin
                  ticks_in = '0;
                  unique case (mode_ff)
                     MODE_HEADER: begin
                        hdr_in[hdr_cnt_ff[1:0]] = byte_in;
                        hdr_cnt_in = hdr_cnt_ff + 3'd1;
                        sum_in     = sum_ff + byte_in;
                        if (hdr_cnt_ff == 3'(sfrp_pkg::HDR_LEN - 1)) begin
                           if (byte_in > 8'(sfrp_pkg::MAX_PAYLOAD)) begin
                              cmd_push   = 1'b1;
                              cmd        = sfrp_pkg::make_cmd(sfrp_pkg::CMD_ERROR,
                                              csr.status_length_error,
                                              hdr_ff[0], hdr_ff[1], hdr_ff[2], '0);
                              mode_in    = MODE_IDLE;
                              hdr_cnt_in = '0;
                              pay_cnt_in = '0;
                              sum_in     = '0;
                           end else begin
                              mode_in = (byte_in == 8'd0) ? MODE_CHECK : MODE_PAYLOAD;
                           end
                        end
                     end
                     MODE_PAYLOAD: begin
                        store_wr.en   = 1'b1;
                        store_wr.addr = pay_cnt_ff[sfrp_pkg::PAY_AW-1:0];
                        store_wr.data = byte_in;
                        pay_cnt_in    = pay_cnt_ff + 1'b1;
                        sum_in        = sum_ff + byte_in;
                        if (8'(pay_cnt_in) >= hdr_ff[3]) begin
                           mode_in = MODE_CHECK;
                        end
                     end
                     MODE_CHECK: begin
                        cmd_push = 1'b1;
                        if (byte_in != sum_ff) begin
                           cmd = sfrp_pkg::make_cmd(sfrp_pkg::CMD_ERROR,
                                    csr.status_sum_error,
                                    hdr_ff[0], hdr_ff[1], hdr_ff[2], '0);
                        end else begin
                           cmd = sfrp_pkg::make_cmd(sfrp_pkg::CMD_ACCEPT, 8'd0,
                                    hdr_ff[0], hdr_ff[1], hdr_ff[2],
                                    hdr_ff[3][sfrp_pkg::LEN_W-1:0]);
                           // store now owned by the back end until the burst ends
                           if (hdr_ff[3] != 8'd0) begin
                              busy_in = 1'b1;
                           end
                        end
                        mode_in    = MODE_IDLE;
                        hdr_cnt_in = '0;
                        pay_cnt_in = '0;
                        sum_in     = '0;
                     end
                     default: begin
                        mode_in = MODE_IDLE;
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         sync_ff    <= '0;
         hdr_cnt_ff <= '0;
         pay_cnt_ff <= '0;
         sum_ff     <= '0;
         ticks_ff   <= '0;
         busy_ff    <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         sync_ff    <= sync_in;
         hdr_cnt_ff <= hdr_cnt_in;
         pay_cnt_ff <= pay_cnt_in;
         sum_ff     <= sum_in;
         ticks_ff   <= ticks_in;
         busy_ff    <= busy_in;
      end
   end

   // header bytes, read only where written in the current frame
   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

endmodule

`default_nettype wire

/* rtl/sfrp_cmd_queue.sv */
// Short command queue between the front end and the back end.
// Depends on sfrp_pkg.
`default_nettype none

module sfrp_cmd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sfrp_pkg::cmd_type  push_data,
   output logic                    full,
   input  wire logic               pop,
   output sfrp_pkg::cmd_type       pop_data,
   output logic                    empty
);

   sfrp_pkg::cmd_type                entry_ff [sfrp_pkg::CMDQ_DEPTH];
   logic [sfrp_pkg::CMDQ_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [sfrp_pkg::CMDQ_CNT_W-1:0]  count_ff, count_in;
   logic                             do_push, do_pop;

   assign full     = (count_ff == sfrp_pkg::CMDQ_CNT_W'(sfrp_pkg::CMDQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/sfrp_back.sv */
// Back end: expands commands into response items and holds the payload store.
// One item per cycle into a response register while it is free or being popped; depends on sfrp_pkg.
`default_nettype none

module sfrp_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_empty,
   input  wire sfrp_pkg::cmd_type      q_data,
   output logic                        q_pop,
   input  wire sfrp_pkg::store_wr_type store_wr,
   output logic                        burst_done,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [1:0]                  rsp_kind,
   output logic [7:0]                  rsp_byte_value,
   output logic [7:0]                  rsp_module_id,
   output logic [7:0]                  rsp_command,
   output logic [7:0]                  rsp_parameter_res,
   output logic [5:0]                  rsp_length,
   output logic                        rsp_last
);

   logic [7:0]                   store_mem [sfrp_pkg::MAX_PAYLOAD];
   logic [7:0]                   rd_data_ff;

   logic                         active_ff, active_in;
   sfrp_pkg::cmd_type            cmd_ff, cmd_in;
   logic [sfrp_pkg::IDX_W-1:0]   idx_ff, idx_in;

   logic                         valid_ff, valid_in;
   logic [1:0]                   kind_ff, kind_in;
   logic [7:0]                   byte_ff, byte_in;
   logic [5:0]                   len_ff, len_in;
   logic                         last_ff, last_in;
   logic [7:0]                   m_ff, c_ff, p_ff;

   logic                         out_free, emit, is_last;
   logic [7:0]                   err_sum, err_byte;

   assign out_free = !valid_ff || rsp_pop;
   assign q_pop    = !active_ff && !q_empty;
   assign emit     = active_ff && out_free;

   // error frame bytes: sync, status, module, command, parameter, zero, sum
   assign err_sum = sfrp_pkg::RESP_SYNC + cmd_ff.status + cmd_ff.module_id
                  + cmd_ff.command + cmd_ff.parameter_res;

   always_comb begin
      case (idx_ff[2:0])
         3'd0:    err_byte = sfrp_pkg::RESP_SYNC;
         3'd1:    err_byte = cmd_ff.status;
         3'd2:    err_byte = cmd_ff.module_id;
         3'd3:    err_byte = cmd_ff.command;
         3'd4:    err_byte = cmd_ff.parameter_res;
         3'd5:    err_byte = 8'd0;
         default: err_byte = err_sum;
      endcase
   end

   // item decode for the current index
   always_comb begin
      unique case (cmd_ff.op)
         sfrp_pkg::CMD_SYNC: begin
            kind_in = sfrp_pkg::KIND_SYNC;
            byte_in = 8'd0;
            len_in  = '0;
            is_last = 1'b1;
         end
         sfrp_pkg::CMD_ACCEPT: begin
            kind_in = sfrp_pkg::KIND_REQ;
            byte_in = (cmd_ff.length == '0) ? 8'd0 : rd_data_ff;
            len_in  = cmd_ff.length;
            is_last = (cmd_ff.length == '0)
                   || ((idx_ff + 1'b1) == sfrp_pkg::IDX_W'(cmd_ff.length));
         end
         sfrp_pkg::CMD_ERROR: begin
            kind_in = sfrp_pkg::KIND_ERR;
            byte_in = err_byte;
            len_in  = '0;
            is_last = (idx_ff == sfrp_pkg::IDX_W'(sfrp_pkg::ERR_FRAME_LEN - 1));
         end
         default: begin
            kind_in = sfrp_pkg::KIND_SYNC;
            byte_in = 8'd0;
            len_in  = '0;
            is_last = 1'b1;
         end
      endcase
   end
   assign last_in = is_last;

   // sequencer over the items of one command
   always_comb begin
      active_in  = active_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      burst_done = 1'b0;
      if (q_pop) begin
         active_in = 1'b1;
         cmd_in    = q_data;
         idx_in    = '0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
         if (is_last) begin
            active_in  = 1'b0;
            burst_done = (cmd_ff.op == sfrp_pkg::CMD_ACCEPT) && (cmd_ff.length != '0);
         end
      end
      valid_in = (valid_ff && !rsp_pop) || emit;
   end

   // payload store: one write port from the front, read ahead at the next index
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr] <= store_wr.data;
      end
      rd_data_ff <= store_mem[idx_in[sfrp_pkg::PAY_AW-1:0]];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         idx_ff    <= idx_in;
      end
   end

   // command and response payload
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (emit) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         m_ff    <= cmd_ff.module_id;
         c_ff    <= cmd_ff.command;
         p_ff    <= cmd_ff.parameter_res;
         len_ff  <= len_in;
         last_ff <= last_in;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_byte_value    = byte_ff;
   assign rsp_module_id     = m_ff;
   assign rsp_command       = c_ff;
   assign rsp_parameter_res = p_ff;
   assign rsp_length        = len_ff;
   assign rsp_last          = last_ff;

endmodule

`default_nettype wire

/* rtl/sync_framed_request_parser.sv */
// Sync-word framed request parser, top level.
// Holds the configuration registers and joins front end, command queue and back end.
//
// Usage:
//   req_ channel (push/full): one request per accepted edge, either a received
//     byte, a millisecond tick or a cancel of the sequence hunt.
//   rsp_ channel (empty/pop): response items, oldest first; a found sequence
//     gives one item, a good frame one item per payload byte (one if empty),
//     a failed frame a 7-byte error response.
//   csr_ channel (valid/ready): register writes, always ready; write only
//     while the block is idle.
// Response path: the first item of a request's response passes the command queue,
//   the back-end sequencer and the response register; further items follow
//   one per cycle while rsp_pop is held.
// Throughput: one request per cycle while req_full is low; the back end takes a burst's
//   command, then emits its items one per cycle while the response register is free or popped.
// A payload byte is held off (req_full high) while the previous frame's
//   payload is still being read out of the store; with the receiver stalled,
//   requests flow on until the two-entry command queue fills.
// Reset: synchronous; hunt, frame and queues are cleared, registers take
//   their default values (timeout 100, status codes 1, 2, 3).
`default_nettype none

module sync_framed_request_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_byte_in,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_byte_value,
   output logic [7:0]       rsp_module_id,
   output logic [7:0]       rsp_command,
   output logic [7:0]       rsp_parameter_res,
   output logic [5:0]       rsp_length,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   sfrp_pkg::csr_type       csr_ff, csr_in;
   sfrp_pkg::cmd_type       cmd, q_data;
   sfrp_pkg::store_wr_type  store_wr;
   logic                    cmd_push, q_full, q_empty, q_pop;
   logic                    burst_done, store_busy;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sfrp_pkg::CSR_TIMEOUT:    csr_in.timeout_ticks       = csr_data;
            sfrp_pkg::CSR_STATUS_IO:  csr_in.status_io_error     = csr_data[7:0];
            sfrp_pkg::CSR_STATUS_LEN: csr_in.status_length_error = csr_data[7:0];
            sfrp_pkg::CSR_STATUS_SUM: csr_in.status_sum_error    = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.timeout_ticks       <= sfrp_pkg::TIMEOUT_RST;
         csr_ff.status_io_error     <= sfrp_pkg::STATUS_IO_RST;
         csr_ff.status_length_error <= sfrp_pkg::STATUS_LEN_RST;
         csr_ff.status_sum_error    <= sfrp_pkg::STATUS_SUM_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // parser front end
   sfrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .action     (req_action),
      .byte_in    (req_byte_in),
      .csr        (csr_ff),
      .cmd_push   (cmd_push),
      .cmd        (cmd),
      .cmd_full   (q_full),
      .store_wr   (store_wr),
      .burst_done (burst_done),
      .store_busy (store_busy)
   );

   // command queue
   sfrp_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   // response back end
   sfrp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_data            (q_data),
      .q_pop             (q_pop),
      .store_wr          (store_wr),
      .burst_done        (burst_done),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kind          (rsp_kind),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_module_id     (rsp_module_id),
      .rsp_command       (rsp_command),
      .rsp_parameter_res (rsp_parameter_res),
      .rsp_length        (rsp_length),
      .rsp_last          (rsp_last)
   );

   // checks
`ifndef ASSERT_OFF
   // a command is never issued into a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !q_full)
      else $error("command issued into full queue");

   // payload is never overwritten while a burst still reads it
   a_store_owned: assert property (@(posedge clock) disable iff (reset)
      store_wr.en |-> !store_busy)
      else $error("payload store written during read-out");

   // a burst can only finish if the store was handed over
   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      burst_done |-> store_busy)
      else $error("burst end without store ownership");

   // no response straight after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("response visible after reset");
`endif

endmodule

`default_nettype wire

/* tb/sync_framed_request_parser_test.sv */
// Self-checking testbench of the sync-word framed request parser: a directed table,
// then random frames over several register settings. Every response is checked
// against a behavioural model held here. Depends on sfrp_pkg and the parser RTL.
module sync_framed_request_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_IGNORED     = 2'd3;  // unused action code
   localparam int         CYCLE_LIMIT     = 1000000;
   localparam int         SETTLE_CYCLES   = 8;
   localparam int         HOLD_OFF_CYCLES = 300;

   // parser model modes
   localparam logic [1:0] PM_IDLE    = 2'd0;
   localparam logic [1:0] PM_HEADER  = 2'd1;
   localparam logic [1:0] PM_PAYLOAD = 2'd2;
   localparam logic [1:0] PM_CHECK   = 2'd3;

   typedef struct packed {
      logic [1:0]                 kind;
      logic [7:0]                 byte_value;
      logic [7:0]                 module_id;
      logic [7:0]                 command;
      logic [7:0]                 parameter_res;
      logic [sfrp_pkg::LEN_W-1:0] length;
      logic                       last;
   } rsp_item_type;

   // one directed request with the response count, first kind and error status
   typedef struct packed {
      logic [1:0] act;
      logic [7:0] data;
      logic [5:0] n;
      logic [1:0] kind;
      logic [7:0] status;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_action = sfrp_pkg::ACT_BYTE;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_byte_value;
   logic [7:0]  rsp_module_id;
   logic [7:0]  rsp_command;
   logic [7:0]  rsp_parameter_res;
   logic [5:0]  rsp_length;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = sfrp_pkg::CSR_TIMEOUT;
   logic [15:0] csr_data = 16'h0000;

   sync_framed_request_parser u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Directed requests: idle tick, unused action, cancel, hunt restart on the first
   // sequence byte, oversized length, then an empty frame with a good checksum.
   stim_row_type stim_table [0:29] = '{
      '{sfrp_pkg::ACT_TICK,   8'h00, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{ACT_IGNORED,          8'hFF, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h91, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_CANCEL, 8'h00, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h91, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h91, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h3E, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'hED, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h20, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h7C, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h99, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h58, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'hAC, 6'd1, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'hFF, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h00, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'hAA, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'hFF, 6'd7, sfrp_pkg::KIND_ERR,  sfrp_pkg::STATUS_LEN_RST},
      '{sfrp_pkg::ACT_BYTE,   8'h91, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h3E, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'hED, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h20, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h7C, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h99, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h58, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'hAC, 6'd1, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h00, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'hFF, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h55, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h00, 6'd0, sfrp_pkg::KIND_SYNC, 8'h00},
      '{sfrp_pkg::ACT_BYTE,   8'h54, 6'd1, sfrp_pkg::KIND_REQ,  8'h00}
   };

   // Parser model state and register copy
   sfrp_pkg::csr_type cfg;
   logic [1:0]        pm_mode;
   int unsigned       hunt_len;
   int unsigned       hdr_cnt;
   logic [7:0]        hdr_bytes [sfrp_pkg::HDR_LEN];
   int unsigned       pay_cnt;
   logic [7:0]        pay_store [sfrp_pkg::MAX_PAYLOAD];
   logic [7:0]        frame_sum;
   int unsigned       quiet_ticks;
   rsp_item_type      expected_rsp [$];

   bit          req_idling = 1'b1;
   bit          rsp_idling = 1'b1;
   bit          hold_off_request = 1'b0;
   int unsigned items_counted = 0;
   int unsigned cycle_count = 0;
   int          fail_count = 0;

   function automatic void add_rsp(input logic [1:0] kind, input logic [7:0] value,
                                   input logic [7:0] m, input logic [7:0] c,
                                   input logic [7:0] p,
                                   input logic [sfrp_pkg::LEN_W-1:0] len,
                                   input logic last);
      rsp_item_type r;
      r = '{kind, value, m, c, p, len, last};
      expected_rsp.push_back(r);
   endfunction

   function automatic void end_frame();
      pm_mode     = PM_IDLE;
      hdr_cnt     = 0;
      pay_cnt     = 0;
      frame_sum   = 8'h00;
      quiet_ticks = 0;
   endfunction

   // AC, status, module, command, parameter, 0, sum of the first six
   function automatic void add_error_frame(input logic [7:0] status, input logic [7:0] m,
                                           input logic [7:0] c, input logic [7:0] p);
      logic [7:0] f [sfrp_pkg::ERR_FRAME_LEN];
      logic [7:0] s;
      f[0] = sfrp_pkg::RESP_SYNC;
      f[1] = status;
      f[2] = m;
      f[3] = c;
      f[4] = p;
      f[5] = 8'h00;
      s = 8'h00;
      for (int i = 0; i < 6; i++) s += f[i];
      f[6] = s;
      for (int i = 0; i < sfrp_pkg::ERR_FRAME_LEN; i++)
         add_rsp(sfrp_pkg::KIND_ERR, f[i], m, c, p, '0,
                 i == sfrp_pkg::ERR_FRAME_LEN - 1);
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      int unsigned len;
      // sequence hunt
      if (pm_mode == PM_IDLE) begin
         if (b == sfrp_pkg::SYNC_SEQ[hunt_len]) hunt_len++;
         else hunt_len = (b == sfrp_pkg::SYNC_SEQ[0]) ? 1 : 0;
         if (hunt_len == sfrp_pkg::SYNC_LEN) begin
            hunt_len = 0;
            end_frame();
            pm_mode = PM_HEADER;
            add_rsp(sfrp_pkg::KIND_SYNC, 8'h00, 8'h00, 8'h00, 8'h00, '0, 1'b1);
         end
         return;
      end
      quiet_ticks = 0;
      len = hdr_bytes[3];
      case (pm_mode)
         PM_HEADER: begin
            hdr_bytes[hdr_cnt] = b;
            hdr_cnt++;
            frame_sum += b;
            if (hdr_cnt == sfrp_pkg::HDR_LEN) begin
               if (hdr_bytes[3] > sfrp_pkg::MAX_PAYLOAD) begin
                  add_error_frame(cfg.status_length_error, hdr_bytes[0], hdr_bytes[1],
                                  hdr_bytes[2]);
                  end_frame();
               end else begin
                  pm_mode = (hdr_bytes[3] == 0) ? PM_CHECK : PM_PAYLOAD;
               end
            end
         end
         PM_PAYLOAD: begin
            pay_store[pay_cnt] = b;
            pay_cnt++;
            frame_sum += b;
            if (pay_cnt >= len) pm_mode = PM_CHECK;
         end
         default: begin
            // checksum byte closes the frame
            if (b != frame_sum)
               add_error_frame(cfg.status_sum_error, hdr_bytes[0], hdr_bytes[1], hdr_bytes[2]);
            else if (len == 0)
               add_rsp(sfrp_pkg::KIND_REQ, 8'h00, hdr_bytes[0], hdr_bytes[1], hdr_bytes[2],
                       '0, 1'b1);
            else
               for (int i = 0; i < len; i++)
                  add_rsp(sfrp_pkg::KIND_REQ, pay_store[i], hdr_bytes[0], hdr_bytes[1],
                          hdr_bytes[2], len[sfrp_pkg::LEN_W-1:0], i == len - 1);
            end_frame();
         end
      endcase
   endfunction

   // returns the number of responses the request adds
   function automatic int parse_request(input logic [1:0] act, input logic [7:0] b);
      int          before_n;
      logic [7:0]  m, c, p;
      before_n = expected_rsp.size();
      case (act)
         sfrp_pkg::ACT_CANCEL: hunt_len = 0;
         sfrp_pkg::ACT_TICK: begin
            if (pm_mode != PM_IDLE) begin
               if (quiet_ticks < 16'hFFFF) quiet_ticks++;
               if (quiet_ticks >= cfg.timeout_ticks) begin
                  // only header bytes already received are reported
                  m = (hdr_cnt > 0) ? hdr_bytes[0] : 8'h00;
                  c = (hdr_cnt > 1) ? hdr_bytes[1] : 8'h00;
                  p = (hdr_cnt > 2) ? hdr_bytes[2] : 8'h00;
                  add_error_frame(cfg.status_io_error, m, c, p);
                  end_frame();
               end
            end
         end
         sfrp_pkg::ACT_BYTE: parse_byte(b);
         default: ;
      endcase
      return expected_rsp.size() - before_n;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // One request: optional idle burst, then hold push until the block takes it.
   task automatic send_req(input logic [1:0] act, input logic [7:0] data, output int n);
      @(negedge clock);
      if (req_idling && $urandom_range(0, 7) == 0) begin
         req_push = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_push    = 1'b1;
      req_action  = act;
      req_byte_in = data;
      @(posedge clock);
      while (req_full) @(posedge clock);
      n = parse_request(act, data);
      items_counted++;
   endtask

   task automatic push_req(input logic [1:0] act, input logic [7:0] data);
      int n;
      send_req(act, data, n);
   endtask

   task automatic req_release();
      @(negedge clock);
      req_push = 1'b0;
   endtask

   // stop sending and let every outstanding response come back
   task automatic drain_responses();
      req_release();
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         sfrp_pkg::CSR_TIMEOUT:    cfg.timeout_ticks       = data;
         sfrp_pkg::CSR_STATUS_IO:  cfg.status_io_error     = data[7:0];
         sfrp_pkg::CSR_STATUS_LEN: cfg.status_length_error = data[7:0];
         default:                  cfg.status_sum_error    = data[7:0];
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_settings(input logic [15:0] timeout, input logic [7:0] io,
                                 input logic [7:0] len_err, input logic [7:0] sum_err);
      drain_responses();
      csr_write(sfrp_pkg::CSR_TIMEOUT, timeout);
      csr_write(sfrp_pkg::CSR_STATUS_IO, {8'h00, io});
      csr_write(sfrp_pkg::CSR_STATUS_LEN, {8'h00, len_err});
      csr_write(sfrp_pkg::CSR_STATUS_SUM, {8'h00, sum_err});
   endtask

   // traffic between frames: stray bytes, broken sequence prefixes, ticks, cancels, unused actions
   task automatic send_noise();
      int unsigned k;
      case ($urandom_range(0, 5))
         0: push_req(sfrp_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
         1: push_req(sfrp_pkg::ACT_CANCEL, 8'($urandom_range(0, 255)));
         2: push_req(ACT_IGNORED, 8'($urandom_range(0, 255)));
         3: begin
            k = $urandom_range(1, sfrp_pkg::SYNC_LEN - 1);
            for (int i = 0; i < k; i++) push_req(sfrp_pkg::ACT_BYTE, sfrp_pkg::SYNC_SEQ[i]);
         end
         default: push_req(sfrp_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic interject();
      case ($urandom_range(0, 39))
         0: push_req(sfrp_pkg::ACT_CANCEL, 8'($urandom_range(0, 255)));
         1: push_req(ACT_IGNORED, 8'($urandom_range(0, 255)));
         2: push_req(sfrp_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
         default: ;
      endcase
   endtask

   // Sequence, header, payload and checksum; sometimes a bad sum, an oversized
   // length or a frame cut short and left to time out.
   task automatic send_frame();
      logic [7:0]  frame_bytes [$];
      logic [7:0]  sum;
      int unsigned r, len, cut;
      for (int i = 0; i < 3; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (r < 8)       len = 0;
      else if (r < 70) len = $urandom_range(1, 8);
      else if (r < 80) len = $urandom_range(9, sfrp_pkg::MAX_PAYLOAD - 1);
      else if (r < 88) len = sfrp_pkg::MAX_PAYLOAD;
      else             len = $urandom_range(sfrp_pkg::MAX_PAYLOAD + 1, 255);
      frame_bytes.push_back(len[7:0]);
      if (len <= sfrp_pkg::MAX_PAYLOAD) begin
         repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
         sum = 8'h00;
         foreach (frame_bytes[i]) sum += frame_bytes[i];
         if ($urandom_range(0, 5) == 0) sum += 8'($urandom_range(1, 255));
         frame_bytes.push_back(sum);
      end
      cut = frame_bytes.size();
      if (cfg.timeout_ticks <= 100 && $urandom_range(0, 9) == 0)
         cut = $urandom_range(0, frame_bytes.size() - 1);
      for (int i = 0; i < sfrp_pkg::SYNC_LEN; i++)
         push_req(sfrp_pkg::ACT_BYTE, sfrp_pkg::SYNC_SEQ[i]);
      for (int i = 0; i < cut; i++) begin
         interject();
         push_req(sfrp_pkg::ACT_BYTE, frame_bytes[i]);
      end
      if (cut < frame_bytes.size())
         repeat (cfg.timeout_ticks) push_req(sfrp_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic random_phase(input int unsigned quota);
      int unsigned stop_at;
      stop_at = items_counted + quota;
      while (items_counted < stop_at) begin
         if ($urandom_range(0, 4) == 0) send_noise();
         else send_frame();
      end
   endtask

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned stall_left, hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop = 1'b0;
         end else if (rsp_idling && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_pop = 1'b0;
         end else begin
            rsp_pop = 1'b1;
         end
      end
   end

   // Compare each taken response with the oldest expectation
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected response: kind %0d, byte_value %0h", rsp_kind, rsp_byte_value);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("byte_value", want.byte_value, rsp_byte_value);
            check_field("module_id", want.module_id, rsp_module_id);
            check_field("command", want.command, rsp_command);
            check_field("parameter_res", want.parameter_res, rsp_parameter_res);
            check_field("length", want.length, rsp_length);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL sync_framed_request_parser");
         $finish;
      end
   end

   initial begin
      int           n;
      rsp_item_type first;
      cfg = '{sfrp_pkg::TIMEOUT_RST, sfrp_pkg::STATUS_IO_RST, sfrp_pkg::STATUS_LEN_RST,
              sfrp_pkg::STATUS_SUM_RST};
      hunt_len = 0;
      foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
      foreach (pay_store[i]) pay_store[i] = 8'h00;
      end_frame();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table, reset register values
      foreach (stim_table[i]) begin
         send_req(stim_table[i].act, stim_table[i].data, n);
         if (n != stim_table[i].n) begin
            $error("row %0d: expected %0d responses, model gives %0d", i, stim_table[i].n, n);
            fail_count++;
         end else if (n > 0) begin
            first = expected_rsp[expected_rsp.size() - n];
            check_field("row kind", stim_table[i].kind, first.kind);
            if (stim_table[i].kind == sfrp_pkg::KIND_ERR)
               check_field("row status", stim_table[i].status,
                           expected_rsp[expected_rsp.size() - n + 1].byte_value);
         end
      end

      random_phase(70);
      apply_settings(16'd1, 8'h00, 8'hFF, 8'h00);
      random_phase(70);
      // long receiver hold-off with the sender still offering requests
      apply_settings(16'hFFFF, 8'hFF, 8'h00, 8'hFF);
      hold_off_request = 1'b1;
      random_phase(80);
      apply_settings(16'($urandom_range(2, 40)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_phase(80);
      // closing stretch without idling on either side
      apply_settings(16'd5, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      random_phase(70);
      drain_responses();

      if (fail_count == 0) $display("PASS sync_framed_request_parser");
      else $display("FAIL sync_framed_request_parser");
      $finish;
   end

endmodule
